@@ rtl/rrl_pkg.sv @@
`default_nettype none

package rrl_pkg;

    localparam int DEV_W  = 16;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 5;
    localparam int OUT_W  = 2;

    localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd10000;
    localparam logic [TIME_W-1:0] TIME_ALL_ONES  = 32'hFFFF_FFFF;

    typedef enum logic [OUT_W-1:0] {
        OUT_REFRESH = 2'd0,
        OUT_DROP    = 2'd1,
        OUT_FREE    = 2'd2,
        OUT_EVICT   = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic              accepted;
        t_outcome          outcome;
        logic [SLOT_W-1:0] slot;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/rrl_if.sv @@
`default_nettype none

interface rrl_in_if;
    logic                        valid;
    logic                        ready;
    logic [rrl_pkg::DEV_W-1:0]   node_id;
    logic [rrl_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output node_id, output now_ms, input ready);
    modport sink (input valid, input node_id, input now_ms, output ready);
endinterface

interface rrl_out_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic [rrl_pkg::OUT_W-1:0]   outcome;
    logic [rrl_pkg::SLOT_W-1:0]  slot;

    modport source (output valid, output accepted, output outcome, output slot,
                    input ready);
    modport sink (input valid, input accepted, input outcome, input slot,
                  output ready);
endinterface

interface rrl_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rrl_pkg::TIME_W-1:0]  min_interval_ms;

    modport source (output valid, output min_interval_ms, input ready);
    modport sink (input valid, input min_interval_ms, output ready);
endinterface

`default_nettype wire

@@ rtl/rrl_ram.sv @@
`default_nettype none

module rrl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/rrl_ctrl.sv @@
`default_nettype none

module rrl_ctrl #(
    parameter int ENTRIES = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [rrl_pkg::DEV_W-1:0]    i_node_id,
    input  wire logic [rrl_pkg::TIME_W-1:0]   i_now_ms,
    input  wire logic [rrl_pkg::TIME_W-1:0]   i_min_interval,
    input  wire logic                         i_res_free,
    output logic                              o_idle,
    output logic                              o_res_valid,
    output rrl_pkg::t_result                  o_res
);

    import rrl_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int MEM_W = DEV_W + TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state r_state, n_state;

    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_cmp_vld;

    logic [DEV_W-1:0]   r_dev;
    logic [TIME_W-1:0]  r_now;

    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [TIME_W-1:0]  r_hit_time;
    logic               r_free;
    logic [IDX_W-1:0]   r_free_idx;
    logic [IDX_W-1:0]   r_victim;
    logic [TIME_W-1:0]  r_oldest;

    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [MEM_W-1:0]   rd_data;
    logic [DEV_W-1:0]   rd_dev;
    logic [TIME_W-1:0]  rd_time;
    logic               cmp_valid;
    logic [TIME_W-1:0]  age;
    logic               drop;
    t_outcome           outcome;

    assign rd_dev    = rd_data[TIME_W +: DEV_W];
    assign rd_time   = rd_data[TIME_W-1:0];
    assign cmp_valid = r_valid[r_cmp_idx];
    assign age       = r_now - r_hit_time;

    rrl_ram #(
        .WIDTH(MEM_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_idx),
        .i_wr_data({r_dev, r_now}),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_rd_idx),
        .o_rd_data(rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_idx == LAST_IDX) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        drop    = 1'b0;
        wr_idx  = r_victim;
        outcome = OUT_EVICT;
        if (r_hit) begin
            wr_idx  = r_hit_idx;
            drop    = (age < i_min_interval);
            outcome = drop ? OUT_DROP : OUT_REFRESH;
        end else if (r_free) begin
            wr_idx  = r_free_idx;
            outcome = OUT_FREE;
        end
        o_idle      = (r_state == S_IDLE);
        rd_en       = (r_state == S_SCAN);
        o_res_valid = (r_state == S_WRITE) && i_res_free;
        wr_en       = o_res_valid && !drop;
        o_res.accepted = !drop;
        o_res.outcome  = outcome;
        o_res.slot     = SLOT_W'(wr_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;
            if (wr_en) begin
                r_valid[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_dev    <= i_node_id;
            r_now    <= i_now_ms;
            r_rd_idx <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_victim <= '0;
            r_oldest <= TIME_ALL_ONES;
        end else begin
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_cmp_vld) begin
                if (cmp_valid && rd_dev == r_dev && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_cmp_idx;
                    r_hit_time <= rd_time;
                end
                if (!cmp_valid && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
                if (cmp_valid && rd_time < r_oldest) begin
                    r_oldest <= rd_time;
                    r_victim <= r_cmp_idx;
                end
            end
        end
        r_cmp_idx <= r_rd_idx;
    end

endmodule

`default_nettype wire

@@ rtl/report_rate_limit_table.sv @@
// Per-device report rate limiter with a table of ENTRIES tracked devices.
// Input channel i_in carries one report (node_id, now_ms) per transaction.
// Output channel o_out carries exactly one result per report: accepted,
// outcome (refreshed, dropped duplicate, new in free entry, new by eviction)
// and the table slot used. Channel i_cfg writes min_interval_ms; it is always
// ready and must only be written while the block is idle.
// The device and time of each entry live in one synchronous RAM, and every
// report walks all entries through its single read port, one per cycle.
// A report is scanned, compared in a last step and written back before its
// result is registered; the next report is taken only once the block is idle.
// The result waits in an output register while the next report is scanned.
// If the receiver stalls, the block finishes the scan and holds in its
// write-back step until the output register is free again.
// Reset clears the valid bits of all entries at once, empties the output
// register and sets min_interval_ms to 10000; no clearing pass is needed.
`default_nettype none

module report_rate_limit_table #(
    parameter int ENTRIES = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rrl_in_if.sink        i_in,
    rrl_cfg_if.sink       i_cfg,
    rrl_out_if.source     o_out
);

    import rrl_pkg::*;

    logic [TIME_W-1:0] r_interval;
    logic              r_out_valid;
    t_result           r_out;

    logic              idle;
    logic              res_valid;
    t_result           res;

    assign i_in.ready  = idle;
    assign i_cfg.ready = 1'b1;

    rrl_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_in.valid && idle),
        .i_node_id     (i_in.node_id),
        .i_now_ms      (i_in.now_ms),
        .i_min_interval(r_interval),
        .i_res_free    (!r_out_valid),
        .o_idle        (idle),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= INTERVAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_interval <= i_cfg.min_interval_ms;
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.accepted = r_out.accepted;
    assign o_out.outcome  = r_out.outcome;
    assign o_out.slot     = r_out.slot;

endmodule

`default_nettype wire

@@ dv/report_rate_limit_table_tb.sv @@
`timescale 1ns / 100ps

module report_rate_limit_table_tb;
    import rrl_pkg::*;

    localparam int          TABLE_ENTRIES = 32;
    localparam int          RANDOM_REPORTS = 1800;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rrl_in_if  report_if ();
    rrl_cfg_if interval_if ();
    rrl_out_if verdict_if ();

    report_rate_limit_table #(
        .ENTRIES(TABLE_ENTRIES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (report_if),
        .i_cfg   (interval_if),
        .o_out   (verdict_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the tracking table and of the interval register.
    logic                tracked_valid [TABLE_ENTRIES];
    logic [DEV_W-1:0]    tracked_device [TABLE_ENTRIES];
    logic [TIME_W-1:0]   tracked_time [TABLE_ENTRIES];
    logic [TIME_W-1:0]   interval_ms;

    t_result     pending_verdicts [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned reports_sent = 0;
    int unsigned burst_left = 0;
    int unsigned stall_left = 0;

    function automatic t_result predict_verdict(input logic [DEV_W-1:0] dev,
                                                input logic [TIME_W-1:0] now);
        t_result           verdict;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest;
        int unsigned       victim;
        bit                have_free;
        victim = 0;
        oldest = TIME_ALL_ONES;
        have_free = 1'b0;
        for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
            if (tracked_valid[i] && tracked_device[i] == dev) begin
                age = now - tracked_time[i];
                verdict.slot = i[SLOT_W-1:0];
                if (age < interval_ms) begin
                    verdict.accepted = 1'b0;
                    verdict.outcome = OUT_DROP;
                end else begin
                    tracked_time[i] = now;
                    verdict.accepted = 1'b1;
                    verdict.outcome = OUT_REFRESH;
                end
                return verdict;
            end
        end
        for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
            if (!have_free) begin
                if (!tracked_valid[i]) begin
                    victim = i;
                    have_free = 1'b1;
                end else if (tracked_time[i] < oldest) begin
                    oldest = tracked_time[i];
                    victim = i;
                end
            end
        end
        tracked_valid[victim] = 1'b1;
        tracked_device[victim] = dev;
        tracked_time[victim] = now;
        verdict.accepted = 1'b1;
        verdict.outcome = have_free ? OUT_FREE : OUT_EVICT;
        verdict.slot = victim[SLOT_W-1:0];
        return verdict;
    endfunction

    task automatic send_report(input logic [DEV_W-1:0] dev, input logic [TIME_W-1:0] now);
        if (burst_left == 0) begin
            report_if.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        report_if.valid   <= 1'b1;
        report_if.node_id <= dev;
        report_if.now_ms  <= now;
        @(posedge i_clk);
        while (!report_if.ready) @(posedge i_clk);
        pending_verdicts.push_back(predict_verdict(dev, now));
        reports_sent++;
        burst_left--;
    endtask

    task automatic wait_idle();
        report_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [TIME_W-1:0] value);
        wait_idle();
        interval_if.valid           <= 1'b1;
        interval_if.min_interval_ms <= value;
        @(posedge i_clk);
        while (!interval_if.ready) @(posedge i_clk);
        interval_if.valid <= 1'b0;
        interval_ms = value;
    endtask

    task automatic test_default_interval();
        send_report(16'h0000, 32'd0);
        send_report(16'h0000, 32'd9999);
        send_report(16'h0000, 32'd10000);
        send_report(16'hFFFF, 32'hFFFF_FFFF);
        send_report(16'hFFFF, 32'h0000_270E);
        send_report(16'hFFFF, 32'h0000_270F);
    endtask

    task automatic test_interval_extremes();
        write_interval(32'd0);
        send_report(16'h0000, 32'd10000);
        send_report(16'hFFFF, 32'h0000_270F);
        write_interval(32'hFFFF_FFFF);
        send_report(16'h0000, 32'd9998);
        send_report(16'h0000, 32'd9999);
        write_interval(32'd1);
        send_report(16'hA5A5, 32'h5A5A_5A5A);
        send_report(16'hA5A5, 32'h5A5A_5A5A);
        send_report(16'hA5A5, 32'h5A5A_5A5B);
    endtask

    task automatic test_eviction_order();
        logic [DEV_W-1:0] fresh_dev;
        write_interval(32'd0);
        // A table full of all-ones times has no older entry, so entry 0 goes.
        for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
            fresh_dev = tracked_valid[i] ? tracked_device[i] : DEV_W'(16'h1000 + i);
            send_report(fresh_dev, TIME_ALL_ONES);
        end
        send_report(16'h2000, 32'h0000_0100);
        send_report(tracked_device[5], 32'd7);
        send_report(tracked_device[9], 32'd7);
        send_report(16'h2001, 32'h0000_0200);
        send_report(16'h2002, 32'h0000_0300);
        send_report(tracked_device[12], 32'hFFFF_FFFE);
        send_report(16'h2003, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic();
        logic [DEV_W-1:0]  id_pool [80];
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] step;
        int unsigned       pool_size;
        int unsigned       round_len;
        int unsigned       kind;
        int unsigned       pick;
        int unsigned       target;
        target = reports_sent + RANDOM_REPORTS;
        while (reports_sent < target) begin
            case ($urandom_range(0, 5))
                0: write_interval(32'd0);
                1: write_interval(32'hFFFF_FFFF);
                2: write_interval(32'd1);
                3: write_interval($urandom_range(2, 64));
                4: write_interval($urandom_range(100, 20000));
                default: write_interval($urandom);
            endcase
            kind = $urandom_range(0, 9);
            pool_size = (kind < 7) ? $urandom_range(4, 40) : $urandom_range(40, 80);
            for (int unsigned i = 0; i < pool_size; i++) begin
                pick = $urandom_range(0, TABLE_ENTRIES - 1);
                if ($urandom_range(0, 2) == 0 && tracked_valid[pick]) begin
                    id_pool[i] = tracked_device[pick];
                end else begin
                    id_pool[i] = DEV_W'($urandom_range(0, 16'hFFFF));
                end
            end
            clock_ms = $urandom;
            round_len = $urandom_range(20, 60);
            for (int unsigned n = 0; n < round_len; n++) begin
                if (kind == 9) begin
                    send_report(DEV_W'($urandom_range(0, 16'hFFFF)), $urandom);
                end else begin
                    case ($urandom_range(0, 5))
                        0: step = '0;
                        1: step = interval_ms - 1;
                        2: step = interval_ms;
                        3: step = $urandom_range(0, 64);
                        4: step = interval_ms + $urandom_range(0, 3);
                        default: step = $urandom;
                    endcase
                    clock_ms = clock_ms + step;
                    send_report(id_pool[$urandom_range(0, pool_size - 1)], clock_ms);
                end
            end
        end
    endtask

    // Receiver: runs of ready separated by short stalls and the odd long one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            verdict_if.ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left == 0) begin
            if (verdict_if.ready) begin
                verdict_if.ready <= 1'b0;
                stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                          : $urandom_range(1, 12);
            end else begin
                verdict_if.ready <= 1'b1;
                stall_left <= $urandom_range(1, 60);
            end
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // Every result transaction is checked against the oldest pending verdict.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && verdict_if.valid && verdict_if.ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: accepted %0d outcome %0d slot %0d",
                       verdict_if.accepted, verdict_if.outcome, verdict_if.slot);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (verdict_if.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d",
                           want.accepted, verdict_if.accepted);
                    mismatch_count++;
                end
                if (verdict_if.outcome !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d",
                           want.outcome, verdict_if.outcome);
                    mismatch_count++;
                end
                if (verdict_if.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, verdict_if.slot);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[report_rate_limit_table] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        report_if.valid = 1'b0;
        report_if.node_id = '0;
        report_if.now_ms = '0;
        interval_if.valid = 1'b0;
        interval_if.min_interval_ms = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tracked_valid[i] = 1'b0;
            tracked_device[i] = '0;
            tracked_time[i] = '0;
        end
        interval_ms = INTERVAL_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_interval();
        test_interval_extremes();
        test_eviction_order();
        test_random_traffic();

        wait_idle();
        repeat (2 * (TABLE_ENTRIES + 3)) @(posedge i_clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("[report_rate_limit_table] OK");
        end else begin
            $display("[report_rate_limit_table] ERROR");
        end
        $finish;
    end

endmodule
